// ===== hdl/r2p_pkg.sv =====
// Shared types, widths and constants of the rect-to-polar converter.
// Used by every module under hdl; depends on nothing else.

package r2p_pkg;

    // Field widths of the data words.
    localparam int DATA_W  = 16;
    localparam int PHASE_W = 16;
    localparam int SQ_W    = 2 * DATA_W;

    // Phase datapath: x and y carry guard bits plus headroom for the CORDIC gain.
    localparam int GUARD_W      = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int XY_W         = DATA_W + GUARD_W + 3;

    // Angles are held in units of pi / 2^ANGLE_FRAC.
    localparam int ANGLE_FRAC  = 24;
    localparam int ANGLE_W     = ANGLE_FRAC + 3;
    localparam int PHASE_SHIFT = ANGLE_FRAC - (PHASE_W - 1);

    localparam logic signed [ANGLE_W-1:0] ANGLE_PI   = ANGLE_W'(1) <<< ANGLE_FRAC;
    localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) <<< (PHASE_SHIFT - 1);
    localparam logic signed [ANGLE_W-1:0] PHASE_MAX  = ANGLE_W'((1 <<< (PHASE_W - 1)) - 1);
    localparam logic signed [ANGLE_W-1:0] PHASE_MIN  = -(ANGLE_W'(1) <<< (PHASE_W - 1));

    // Stage counts of the two datapaths and the common pipeline depth.
    localparam int MAG_STAGES   = DATA_W + 4;
    localparam int PHASE_STAGES = CORDIC_STEPS + 2;
    localparam int PIPE_DEPTH   = (MAG_STAGES > PHASE_STAGES) ? MAG_STAGES : PHASE_STAGES;

    // Input word: one spectrum bin.
    typedef struct packed {
        logic signed [DATA_W-1:0] real_part;
        logic signed [DATA_W-1:0] imag_part;
        logic                     last_in;
    } r2p_in_t;

    // Output word: magnitude and phase of one bin.
    typedef struct packed {
        logic [DATA_W-1:0]         magnitude;
        logic signed [PHASE_W-1:0] phase_angle;
        logic                      last_out;
    } r2p_out_t;

    // Rotation angles round(atan(2^-i) * 2^24 / pi).
    function automatic logic signed [ANGLE_W-1:0] atan_step(input int idx);
        logic signed [ANGLE_W-1:0] val;
        unique case (idx)
            0:       val = ANGLE_W'(4194304);
            1:       val = ANGLE_W'(2476042);
            2:       val = ANGLE_W'(1308273);
            3:       val = ANGLE_W'(664100);
            4:       val = ANGLE_W'(333339);
            5:       val = ANGLE_W'(166832);
            6:       val = ANGLE_W'(83436);
            7:       val = ANGLE_W'(41721);
            8:       val = ANGLE_W'(20861);
            9:       val = ANGLE_W'(10430);
            10:      val = ANGLE_W'(5215);
            11:      val = ANGLE_W'(2608);
            12:      val = ANGLE_W'(1304);
            13:      val = ANGLE_W'(652);
            14:      val = ANGLE_W'(326);
            15:      val = ANGLE_W'(163);
            16:      val = ANGLE_W'(81);
            17:      val = ANGLE_W'(41);
            18:      val = ANGLE_W'(20);
            19:      val = ANGLE_W'(10);
            20:      val = ANGLE_W'(5);
            21:      val = ANGLE_W'(3);
            22:      val = ANGLE_W'(1);
            23:      val = ANGLE_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/r2p_mag_pipe.sv =====
// Magnitude datapath: absolute values, squares, sum and a one-bit-per-stage square root.
// Depends on r2p_pkg; stage loads are driven by the pipeline control in the top level.

module r2p_mag_pipe
    import r2p_pkg::*;
(
    input  logic                     aclk,
    input  logic [PIPE_DEPTH-1:0]    stage_en,
    input  logic signed [DATA_W-1:0] re_i,
    input  logic signed [DATA_W-1:0] im_i,
    output logic [DATA_W-1:0]        mag_o
);

    localparam int SQRT_FIRST = 3;
    localparam int RND_STAGE  = SQRT_FIRST + DATA_W;
    localparam int MAG_PAD    = PIPE_DEPTH - MAG_STAGES;
    localparam int TRIAL_W    = SQ_W + 1;

    logic [DATA_W-1:0] abs_re_reg, abs_re_next;
    logic [DATA_W-1:0] abs_im_reg, abs_im_next;
    logic [SQ_W-1:0]   sq_re_reg, sq_re_next;
    logic [SQ_W-1:0]   sq_im_reg, sq_im_next;
    logic [SQ_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]   rem_reg  [DATA_W];
    logic [DATA_W-1:0] root_reg [DATA_W];
    logic [DATA_W-1:0] mag_rnd_reg, mag_rnd_next;

    // Stage 0: absolute values. The most negative input maps to its unsigned magnitude.
    always_comb begin
        abs_re_next = re_i[DATA_W-1] ? DATA_W'(-re_i) : DATA_W'(re_i);
        abs_im_next = im_i[DATA_W-1] ? DATA_W'(-im_i) : DATA_W'(im_i);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            abs_re_reg <= abs_re_next;
            abs_im_reg <= abs_im_next;
        end
    end

    // Stage 1: squares, one multiplier each.
    always_comb begin
        sq_re_next = SQ_W'(abs_re_reg) * SQ_W'(abs_re_reg);
        sq_im_next = SQ_W'(abs_im_reg) * SQ_W'(abs_im_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
        end
    end

    // Stage 2: sum of squares. It cannot overflow, since each square is at most 2^(2W-2).
    assign sum_next = sq_re_reg + sq_im_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            sum_reg <= sum_next;
        end
    end

    // Square root stages: each one settles one root bit, from the top down.
    for (genvar j = 0; j < DATA_W; j++) begin : g_sqrt
        localparam int BIT = DATA_W - 1 - j;

        logic [SQ_W-1:0]    rem_src;
        logic [DATA_W-1:0]  root_src;
        logic [TRIAL_W-1:0] trial;
        logic [SQ_W-1:0]    rem_next;
        logic [DATA_W-1:0]  root_next;

        if (j == 0) begin : g_head
            assign rem_src  = sum_reg;
            assign root_src = '0;
        end else begin : g_body
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
        end

        // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
        always_comb begin
            trial = (TRIAL_W'(root_src) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
            if (TRIAL_W'(rem_src) >= trial) begin
                rem_next  = rem_src - SQ_W'(trial);
                root_next = root_src | (DATA_W'(1) << BIT);
            end else begin
                rem_next  = rem_src;
                root_next = root_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[SQRT_FIRST + j]) begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    // Rounding stage: s > r*r + r is the same as remainder > r.
    assign mag_rnd_next = root_reg[DATA_W-1]
                        + DATA_W'(rem_reg[DATA_W-1] > SQ_W'(root_reg[DATA_W-1]));

    always_ff @(posedge aclk) begin
        if (stage_en[RND_STAGE]) begin
            mag_rnd_reg <= mag_rnd_next;
        end
    end

    // Delay stages that line the magnitude up with the phase.
    if (MAG_PAD > 0) begin : g_pad
        logic [DATA_W-1:0] mag_dly_reg [MAG_PAD];

        for (genvar p = 0; p < MAG_PAD; p++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (stage_en[MAG_STAGES + p]) begin
                    if (p == 0) begin
                        mag_dly_reg[p] <= mag_rnd_reg;
                    end else begin
                        mag_dly_reg[p] <= mag_dly_reg[(p == 0) ? 0 : p - 1];
                    end
                end
            end
        end

        assign mag_o = mag_dly_reg[MAG_PAD-1];
    end else begin : g_nopad
        assign mag_o = mag_rnd_reg;
    end

endmodule

// ===== hdl/r2p_cordic_pipe.sv =====
// Phase datapath: quadrant fold, 24 vectoring CORDIC stages and final rounding.
// Depends on r2p_pkg; stage loads are driven by the pipeline control in the top level.

module r2p_cordic_pipe
    import r2p_pkg::*;
(
    input  logic                      aclk,
    input  logic [PIPE_DEPTH-1:0]     stage_en,
    input  logic signed [DATA_W-1:0]  re_i,
    input  logic signed [DATA_W-1:0]  im_i,
    output logic signed [PHASE_W-1:0] phase_o
);

    localparam int RND_STAGE = CORDIC_STEPS + 1;
    localparam int PH_PAD    = PIPE_DEPTH - PHASE_STAGES;

    logic signed [XY_W-1:0]    x_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]    y_reg    [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] z_reg    [CORDIC_STEPS+1];
    logic                      zero_reg [CORDIC_STEPS+1];

    logic signed [XY_W-1:0]    re_w, im_w;
    logic signed [XY_W-1:0]    x0_next, y0_next;
    logic signed [ANGLE_W-1:0] z0_next;
    logic                      zero0_next;

    logic signed [ANGLE_W-1:0] z_round, z_scaled;
    logic signed [PHASE_W-1:0] phase_rnd_reg, phase_rnd_next;

    // Stage 0: fold the left half-plane over by pi and scale up by the guard bits.
    always_comb begin
        re_w       = XY_W'(re_i);
        im_w       = XY_W'(im_i);
        zero0_next = (re_i == '0) && (im_i == '0);
        if (re_i[DATA_W-1]) begin
            x0_next = (-re_w) <<< GUARD_W;
            y0_next = (-im_w) <<< GUARD_W;
            z0_next = im_i[DATA_W-1] ? -ANGLE_PI : ANGLE_PI;
        end else begin
            x0_next = re_w <<< GUARD_W;
            y0_next = im_w <<< GUARD_W;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= zero0_next;
        end
    end

    // Vectoring stages: rotate toward the positive x axis and accumulate the angle.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [XY_W-1:0]    xs, ys;
        logic signed [XY_W-1:0]    x_next, y_next;
        logic signed [ANGLE_W-1:0] z_next;

        always_comb begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (!y_reg[i][XY_W-1]) begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + atan_step(i);
            end else begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - atan_step(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[i + 1]) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Round half up to units of pi / 2^15 and saturate; the origin reads zero.
    always_comb begin
        z_round  = z_reg[CORDIC_STEPS] + ROUND_HALF;
        z_scaled = z_round >>> PHASE_SHIFT;
        if (zero_reg[CORDIC_STEPS]) begin
            phase_rnd_next = '0;
        end else if (z_scaled > PHASE_MAX) begin
            phase_rnd_next = PHASE_W'(PHASE_MAX);
        end else if (z_scaled < PHASE_MIN) begin
            phase_rnd_next = PHASE_W'(PHASE_MIN);
        end else begin
            phase_rnd_next = PHASE_W'(z_scaled);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[RND_STAGE]) begin
            phase_rnd_reg <= phase_rnd_next;
        end
    end

    // Delay stages used only when the magnitude path is the longer one.
    if (PH_PAD > 0) begin : g_pad
        logic signed [PHASE_W-1:0] phase_dly_reg [PH_PAD];

        for (genvar p = 0; p < PH_PAD; p++) begin : g_dly
            always_ff @(posedge aclk) begin
                if (stage_en[PHASE_STAGES + p]) begin
                    if (p == 0) begin
                        phase_dly_reg[p] <= phase_rnd_reg;
                    end else begin
                        phase_dly_reg[p] <= phase_dly_reg[(p == 0) ? 0 : p - 1];
                    end
                end
            end
        end

        assign phase_o = phase_dly_reg[PH_PAD-1];
    end else begin : g_nopad
        assign phase_o = phase_rnd_reg;
    end

endmodule

// ===== hdl/rect_to_polar_converter.sv =====
// Top level of the rect-to-polar converter: pipeline control, last flag and config register.
// Depends on r2p_pkg, r2p_mag_pipe and r2p_cordic_pipe.
//
//  Channel  Ports                         Word      Direction
//  -------  ----------------------------  --------  ---------
//  input    s_valid, s_ready, s_data      r2p_in_t  in
//  result   m_valid, m_ready, m_data      r2p_out_t out
//  config   cfg_valid, cfg_ready, cfg_data  1 bit   in
//
// One word enters per cycle while s_ready is high; each word passes PIPE_DEPTH (26) stages,
// a figure set by the 24 CORDIC stages plus the fold and rounding stages.
// Every stage holds a valid bit and loads whenever it or some later stage is empty,
// so bubbles collapse and a word is accepted even while a result waits at the output.
// A stall at the output freezes each stage once it and every stage after it are full.
// Reset clears all valid bits and sets phase_enable; the config port is always ready.

module rect_to_polar_converter
    import r2p_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,

    input  logic     s_valid,
    output logic     s_ready,
    input  r2p_in_t  s_data,

    output logic     m_valid,
    input  logic     m_ready,
    output r2p_out_t m_data,

    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    logic [PIPE_DEPTH-1:0]     v_reg, v_next;
    logic [PIPE_DEPTH-1:0]     stage_en;
    logic [PIPE_DEPTH-1:0]     last_reg, last_next;
    logic                      phase_en_reg, phase_en_next;
    logic [DATA_W-1:0]         mag;
    logic signed [PHASE_W-1:0] phase;

    // A stage may load when the output is free or some stage at or after it is empty.
    always_comb begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            stage_en[k] = m_ready
                        || ((v_reg | PIPE_DEPTH'((64'(1) << k) - 64'(1))) != '1);
        end
    end

    assign s_ready = stage_en[0];

    // Valid bits and the last flag move along with the data.
    always_comb begin
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (!stage_en[k]) begin
                v_next[k]    = v_reg[k];
                last_next[k] = last_reg[k];
            end else if (k == 0) begin
                v_next[k]    = s_valid;
                last_next[k] = s_data.last_in;
            end else begin
                v_next[k]    = v_reg[(k == 0) ? 0 : k - 1];
                last_next[k] = last_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
    end

    // Configuration register: phase output on or off.
    assign cfg_ready     = 1'b1;
    assign phase_en_next = (cfg_valid && cfg_ready) ? cfg_data : phase_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_en_reg <= 1'b1;
        end else begin
            phase_en_reg <= phase_en_next;
        end
    end

    // Magnitude and phase datapaths share the stage loads.
    r2p_mag_pipe u_mag (
        .aclk     (aclk),
        .stage_en (stage_en),
        .re_i     (s_data.real_part),
        .im_i     (s_data.imag_part),
        .mag_o    (mag)
    );

    r2p_cordic_pipe u_cordic (
        .aclk     (aclk),
        .stage_en (stage_en),
        .re_i     (s_data.real_part),
        .im_i     (s_data.imag_part),
        .phase_o  (phase)
    );

    // Result word from the last stage.
    assign m_valid            = v_reg[PIPE_DEPTH-1];
    assign m_data.magnitude   = mag;
    assign m_data.phase_angle = phase_en_reg ? phase : '0;
    assign m_data.last_out    = last_reg[PIPE_DEPTH-1];

    // The input is held off only when every stage is full and the output is stalled.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&v_reg) && !m_ready))
        else $error("input held off while the pipeline has room");

    // An accepted word occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted word missing from the first stage");

    // Zero magnitude only comes from the origin, whose phase is zero.
    a_origin_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.magnitude == '0)) |-> (m_data.phase_angle == '0))
        else $error("nonzero phase on a zero-magnitude result");

endmodule

// ===== bench/rect_to_polar_converter_tb.sv =====
// Self-checking testbench for rect_to_polar_converter: magnitude, phase and last flag of each bin.
// Depends on r2p_pkg and the converter RTL; predicts each result with its own CORDIC and root.
`timescale 1ns / 100ps

module rect_to_polar_converter_tb;
    import r2p_pkg::*;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    localparam logic signed [DATA_W-1:0] PART_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] PART_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam longint HALF_TURN    = 64'sd1 <<< 24;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     QUIET_LIMIT  = 3000;
    localparam int     REPORT_LIMIT = 10;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    r2p_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    r2p_out_t m_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    // Rotation angles of the vectoring steps, in units of pi / 2^24.
    longint arctan_step [0:23] = '{
        4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1
    };

    r2p_out_t polar_expected [$];
    r2p_out_t want_word;
    bit       phase_on_model;
    bit       moved;
    int       fault_count   = 0;
    int       words_out     = 0;
    int       quiet_cycles  = 0;
    int       send_pct      = 0;
    int       recv_pct      = 0;
    int       hold_requests = 0;
    int       holds_served  = 0;

    rect_to_polar_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Square root of the sum of squares, rounded to the nearest integer.
    function automatic longint unsigned rounded_root(input longint unsigned sq);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        if (sq > root * root + root)
            root++;
        return root;
    endfunction

    // Vectoring CORDIC angle, scaled so that pi is 32768, saturated to 16 bits.
    function automatic logic signed [PHASE_W-1:0] cordic_angle(input longint re, input longint im);
        longint x, y, z, nx, ny;
        if (re == 0 && im == 0)
            return '0;
        // Fold the left half plane over by a half turn first.
        if (re < 0) begin
            x = -re;
            y = -im;
            z = (im >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            x = re;
            y = im;
            z = 0;
        end
        x = x <<< 16;
        y = y <<< 16;
        for (int i = 0; i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + arctan_step[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - arctan_step[i];
            end
            x = nx;
            y = ny;
        end
        z = (z + 256) >>> 9;
        if (z > 32767)
            z = 32767;
        if (z < -32768)
            z = -32768;
        return z[PHASE_W-1:0];
    endfunction

    // Expected result word of one bin under the given phase setting.
    function automatic r2p_out_t polar_of_bin(input r2p_in_t bin, input bit phase_on);
        longint   re, im;
        r2p_out_t res;
        re = longint'($signed(bin.real_part));
        im = longint'($signed(bin.imag_part));
        res.magnitude   = DATA_W'(rounded_root(longint'(re * re + im * im)));
        res.phase_angle = phase_on ? cordic_angle(re, im) : '0;
        res.last_out    = bin.last_in;
        return res;
    endfunction

    // Predict on every accepted input word and check every accepted result word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            phase_on_model = 1'b1;
            quiet_cycles   = 0;
        end else begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                polar_expected.push_back(polar_of_bin(s_data, phase_on_model));
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                phase_on_model = cfg_data;
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (polar_expected.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("word %0d unexpected: mag %0d phase %0d last %0b",
                                 words_out, m_data.magnitude, m_data.phase_angle,
                                 m_data.last_out);
                end else begin
                    want_word = polar_expected.pop_front();
                    if (m_data.magnitude !== want_word.magnitude ||
                        m_data.phase_angle !== want_word.phase_angle ||
                        m_data.last_out !== want_word.last_out) begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display("word %0d: expected mag %0d phase %0d last %0b, got mag %0d phase %0d last %0b",
                                     words_out, want_word.magnitude, want_word.phase_angle,
                                     want_word.last_out, m_data.magnitude,
                                     m_data.phase_angle, m_data.last_out);
                    end
                end
                words_out++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_served++;
            end
            m_ready = !(recv_pct != 0 && $urandom_range(99) < recv_pct);
        end
    end

    // Watchdog: too long without any word moving ends the run.
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(negedge aclk);
        $display("status: fail");
        $finish;
    end

    // Offer one bin after a random gap and hold it until it is taken.
    task automatic send_bin(input logic signed [DATA_W-1:0] re,
                            input logic signed [DATA_W-1:0] im, input bit last);
        int gap;
        gap = 0;
        while (send_pct != 0 && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data.real_part = re;
        s_data.imag_part = im;
        s_data.last_in   = last;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Random component, weighted toward small values and the extremes.
    function automatic logic signed [DATA_W-1:0] random_part();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return DATA_W'(int'($urandom_range(16)) - 8);
        if (pick == 1) begin
            case ($urandom_range(3))
                0:       return PART_MIN;
                1:       return PART_MAX;
                2:       return '0;
                default: return DATA_W'(-1);
            endcase
        end
        return DATA_W'($urandom);
    endfunction

    task automatic send_random_bin();
        logic signed [DATA_W-1:0] re, im;
        re = random_part();
        im = random_part();
        // Now and then put the bin on an axis.
        case ($urandom_range(15))
            0:       re = '0;
            1:       im = '0;
            default: ;
        endcase
        send_bin(re, im, $urandom_range(7) == 0);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic settle_pipeline();
        s_valid = 1'b0;
        while (polar_expected.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_phase_enable(input bit enable);
        cfg_data  = enable;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Corners with phase on from reset: origin, axes, extremes and the negative real axis.
    task automatic test_corner_bins();
        send_pct = 0;
        recv_pct = 0;
        send_bin('0, '0, 1'b0);
        send_bin(PART_MIN, '0, 1'b0);
        send_bin(DATA_W'(-1), '0, 1'b0);
        send_bin(PART_MAX, '0, 1'b0);
        send_bin('0, PART_MAX, 1'b0);
        send_bin('0, PART_MIN, 1'b0);
        send_bin(PART_MIN, PART_MIN, 1'b1);
        send_bin(PART_MAX, PART_MAX, 1'b0);
        send_bin(PART_MIN, PART_MAX, 1'b0);
        send_bin(PART_MAX, PART_MIN, 1'b0);
        send_bin(PART_MIN, DATA_W'(-1), 1'b0);
        send_bin(PART_MIN, DATA_W'(1), 1'b0);
        send_bin(DATA_W'(1), DATA_W'(1), 1'b0);
        send_bin(DATA_W'(3), DATA_W'(4), 1'b0);
        send_bin(DATA_W'(-3), DATA_W'(-4), 1'b0);
        send_bin(DATA_W'(1), DATA_W'(-1), 1'b0);
        send_bin('0, DATA_W'(1), 1'b1);
    endtask

    // With phase off the angle reads zero while magnitude and last pass as usual.
    task automatic test_phase_off();
        settle_pipeline();
        write_phase_enable(1'b0);
        send_bin('0, '0, 1'b0);
        send_bin(PART_MIN, '0, 1'b1);
        send_bin(DATA_W'(12345), DATA_W'(-23456), 1'b0);
        send_bin(PART_MIN, PART_MIN, 1'b0);
        send_bin(DATA_W'(-7), DATA_W'(3), 1'b0);
        send_bin(PART_MAX, DATA_W'(1), 1'b1);
    endtask

    task automatic test_random_traffic(input idle_mode_t mode, input bit phase_on,
                                       input int count);
        settle_pipeline();
        write_phase_enable(phase_on);
        case (mode)
            IDLE_NONE: begin
                send_pct = 0;
                recv_pct = 0;
            end
            IDLE_SENDER: begin
                send_pct = 83;
                recv_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_pct = 0;
                recv_pct = 83;
            end
            default: begin
                send_pct = 35;
                recv_pct = 35;
            end
        endcase
        repeat (count) send_random_bin();
    endtask

    // Hold the result side off so the pipeline fills and stalls its input, then
    // pause the sender until everything has drained and send again.
    task automatic test_fill_and_stall();
        settle_pipeline();
        write_phase_enable(1'b1);
        send_pct = 0;
        recv_pct = 0;
        hold_requests++;
        repeat (60) send_random_bin();
        settle_pipeline();
        repeat (20) send_random_bin();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_corner_bins();
        test_phase_off();
        test_random_traffic(IDLE_NONE, 1'b1, 90);
        test_random_traffic(IDLE_SENDER, 1'b0, 90);
        test_random_traffic(IDLE_RECEIVER, 1'b1, 90);
        test_random_traffic(IDLE_BOTH, 1'b0, 90);
        test_random_traffic(IDLE_BOTH, 1'b1, 90);
        test_fill_and_stall();

        // Let any stray result show up before the verdict.
        settle_pipeline();
        repeat (2 * PIPE_DEPTH) @(negedge aclk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
